// File: hdl/priority_queue_with_wait_time_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the priority queue block.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_WITH_WAIT_TIME_UNIT_MACROS_SVH
`define PRIORITY_QUEUE_WITH_WAIT_TIME_UNIT_MACROS_SVH

// same-cycle implication
`define PQWT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pqwt assertion failed");

// next-cycle implication
`define PQWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pqwt assertion failed");

`endif

// File: hdl/pqwt_pkg.sv
// ----------------------------------------------------------------------------
// pqwt_pkg
// Types and codes shared by the priority queue cells, channels and top level.
// ----------------------------------------------------------------------------
package pqwt_pkg;

  localparam int TIME_W = 12;
  localparam int PRIO_W = 8;
  localparam int WAIT_W = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [WAIT_W-1:0] WAIT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] service_time;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WAIT_W-1:0] wait_time;
    logic [TIME_W-1:0] popped_time;
    logic [TIME_W-1:0] head_time;
    logic              is_empty;
  } rsp_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic              valid;
    logic              le;
    logic [TIME_W-1:0] svc_time;
    logic [PRIO_W-1:0] prio;
  } cell_link_t;

  // broadcast to every cell
  typedef struct packed {
    logic              do_insert;
    logic              do_pop;
    logic [TIME_W-1:0] svc_time;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] head_time;
  } cell_ctrl_t;

endpackage

// File: hdl/pqwt_stream_ifs.sv
// ----------------------------------------------------------------------------
// pqwt request and result channels
// Valid/ready channels carrying one request or one result.
// ----------------------------------------------------------------------------
interface pqwt_req_if;
  import pqwt_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pqwt_rsp_if;
  import pqwt_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/pqwt_cell.sv
// ----------------------------------------------------------------------------
// pqwt_cell
// One queue slot: job time, priority and running sum of times up to here.
// Shifts right on an insert ahead of it, left on pop.
// ----------------------------------------------------------------------------
module pqwt_cell #(
  parameter int CUM_W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pqwt_pkg::cell_ctrl_t ctrl,
  input  pqwt_pkg::cell_link_t left,
  input  logic [CUM_W-1:0]     left_cum,
  input  pqwt_pkg::cell_link_t right,
  input  logic [CUM_W-1:0]     right_cum,
  output pqwt_pkg::cell_link_t link,
  output logic [CUM_W-1:0]     cum
);
  import pqwt_pkg::*;

  logic              valid;
  logic [TIME_W-1:0] svc_time;
  logic [PRIO_W-1:0] prio;
  logic              le;

  assign le = valid && (prio <= ctrl.prio);
  assign link = '{valid: valid, le: le, svc_time: svc_time, prio: prio};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.do_insert) begin
      priority if (le) begin
        valid <= valid;
      end else if (left.le) begin
        valid    <= 1'b1;
        svc_time <= ctrl.svc_time;
        prio     <= ctrl.prio;
        cum      <= left_cum + CUM_W'(ctrl.svc_time);
      end else begin
        valid    <= left.valid;
        svc_time <= left.svc_time;
        prio     <= left.prio;
        cum      <= left_cum + CUM_W'(ctrl.svc_time);
      end
    end else if (ctrl.do_pop) begin
      valid    <= right.valid;
      svc_time <= right.svc_time;
      prio     <= right.prio;
      cum      <= right_cum - CUM_W'(ctrl.head_time);
    end
  end

endmodule

// File: hdl/priority_queue_with_wait_time_unit.sv
// ----------------------------------------------------------------------------
// priority_queue_with_wait_time_unit
// Sorted job queue built from a row of slot cells, with waiting-time report.
// ----------------------------------------------------------------------------
// Every request (insert, pop, query) is resolved across the row
// of QUEUE_DEPTH slot cells: each cell compares its priority with the new
// job's and keeps, loads or shifts from a neighbor; on pop all cells shift
// toward the head. Each cell carries the running sum of service times up to
// itself, so an insert's waiting time is read from the last cell ahead of the
// new job. The result goes to an output register; a new request is taken
// whenever that register is empty or being read, giving one request per
// cycle while rsp is not stalled, with the result in the next cycle.
module priority_queue_with_wait_time_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  pqwt_req_if.sink  req,
  pqwt_rsp_if.source rsp
);
  import pqwt_pkg::*;

  `include "priority_queue_with_wait_time_unit_macros.svh"

  localparam int CUM_W = TIME_W + $clog2(QUEUE_DEPTH);

  localparam cell_link_t HEAD_LINK = '{valid: 1'b0, le: 1'b1, svc_time: '0, prio: '0};
  localparam cell_link_t TAIL_LINK = '{valid: 1'b0, le: 1'b0, svc_time: '0, prio: '0};

  cell_link_t       link [QUEUE_DEPTH];
  logic [CUM_W-1:0] cum  [QUEUE_DEPTH];
  cell_ctrl_t       ctrl;

  logic [QUEUE_DEPTH-1:0] valid_vec;
  logic [QUEUE_DEPTH-1:0] le_vec;
  logic [QUEUE_DEPTH-1:0] sel_vec;

  logic              accept;
  logic              full;
  logic              empty;
  logic [CUM_W-1:0]  wait_sel;
  logic [31:0]       wait_wide;
  logic [WAIT_W-1:0] wait_sat;

  logic              rsp_valid;
  logic [1:0]        rsp_status;
  logic [WAIT_W-1:0] rsp_wait;
  logic [TIME_W-1:0] rsp_popped;

  assign accept = req.valid && req.ready;
  assign full   = link[QUEUE_DEPTH-1].valid;
  assign empty  = !link[0].valid;

  assign ctrl = '{
    do_insert: accept && (req.payload.command == CMD_INSERT) && !full,
    do_pop:    accept && (req.payload.command == CMD_POP) && !empty,
    svc_time:  req.payload.service_time,
    prio:      req.payload.priority_req,
    head_time: link[0].svc_time
  };

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_link_t       left_l;
    logic [CUM_W-1:0] left_c;
    cell_link_t       right_l;
    logic [CUM_W-1:0] right_c;

    if (i == 0) begin : g_head
      assign left_l = HEAD_LINK;
      assign left_c = '0;
    end else begin : g_mid_l
      assign left_l = link[i-1];
      assign left_c = cum[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_l = TAIL_LINK;
      assign right_c = '0;
    end else begin : g_mid_r
      assign right_l = link[i+1];
      assign right_c = cum[i+1];
    end

    pqwt_cell #(.CUM_W(CUM_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left      (left_l),
      .left_cum  (left_c),
      .right     (right_l),
      .right_cum (right_c),
      .link      (link[i]),
      .cum       (cum[i])
    );

    assign valid_vec[i] = link[i].valid;
    assign le_vec[i]    = link[i].le;
    assign sel_vec[i]   = link[i].le && !right_l.le;
  end

  // last job ahead of the new one holds the wait sum
  always_comb begin
    wait_sel = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      wait_sel = wait_sel | (sel_vec[i] ? cum[i] : '0);
    end
  end

  assign wait_wide = 32'(wait_sel);
  assign wait_sat  = (wait_wide > 32'(WAIT_MAX)) ? WAIT_MAX : wait_wide[WAIT_W-1:0];

  assign req.ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid  <= 1'b1;
      rsp_status <= ST_OK;
      rsp_wait   <= '0;
      rsp_popped <= '0;
      unique case (req.payload.command)
        CMD_INSERT: begin
          if (full) begin
            rsp_status <= ST_FULL;
          end else begin
            rsp_wait <= wait_sat;
          end
        end
        CMD_POP: begin
          if (empty) begin
            rsp_status <= ST_EMPTY;
          end else begin
            rsp_popped <= link[0].svc_time;
          end
        end
        default: begin
          rsp_status <= ST_OK;
        end
      endcase
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // queue state only moves on an accepted request, which reloads the result
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = '{
    status:      rsp_status,
    wait_time:   rsp_wait,
    popped_time: rsp_popped,
    head_time:   link[0].valid ? link[0].svc_time : '0,
    is_empty:    !link[0].valid
  };

  `PQWT_ASSERT_NOW(a_valid_prefix, clk, rst, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
  `PQWT_ASSERT_NOW(a_le_prefix, clk, rst, 1'b1, ((le_vec >> 1) & ~le_vec) == '0)
  `PQWT_ASSERT_NOW(a_sel_onehot, clk, rst, 1'b1, $onehot0(sel_vec))
  `PQWT_ASSERT_NEXT(a_insert_grows, clk, rst, ctrl.do_insert, $countones(valid_vec) == $countones($past(valid_vec)) + 1)
  `PQWT_ASSERT_NEXT(a_stall_holds, clk, rst, rsp.valid && !rsp.ready, $stable(valid_vec))

endmodule
